// ===== rtl/core/hdlf_pkg.sv =====
`timescale 1ns / 1ps

package hdlf_pkg;

  localparam int unsigned BytesPerLine = 16;
  localparam int unsigned FillW        = $clog2(BytesPerLine);
  localparam int unsigned CountW       = FillW + 1;
  localparam int unsigned AddrW        = 64;
  localparam int unsigned NibbleCnt    = AddrW / 4;
  localparam int unsigned CharW        = 7;

  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  localparam logic [CharW-1:0] ChColon  = CharW'(8'h3A);
  localparam logic [CharW-1:0] ChSpace  = CharW'(8'h20);
  localparam logic [CharW-1:0] ChZero   = CharW'(8'h30);
  localparam logic [CharW-1:0] ChBar    = CharW'(8'h7C);
  localparam logic [CharW-1:0] ChDot    = CharW'(8'h2E);
  localparam logic [CharW-1:0] ChTilde  = CharW'(8'h7E);
  localparam logic [CharW-1:0] ChCr     = CharW'(8'h0D);
  localparam logic [CharW-1:0] ChLf     = CharW'(8'h0A);
  localparam logic [CharW-1:0] ChUpperA = CharW'(8'h41);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_BYTE,
    S_PAD,
    S_BAR,
    S_ASCII,
    S_CR,
    S_LF
  } state_e;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             run_last;
  } beat_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] res;
    if (nib < 4'd10) begin
      res = ChZero + CharW'(nib);
    end else begin
      res = ChUpperA + CharW'(nib - 4'd10);
    end
    return res;
  endfunction

  function automatic logic [CharW-1:0] shown_char(input logic [7:0] b);
    logic [CharW-1:0] res;
    if (b >= 8'h20 && b <= {1'b0, ChTilde}) begin
      res = b[CharW-1:0];
    end else begin
      res = ChDot;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/hex_dump_line_formatter_unit.sv =====
`timescale 1ns / 1ps
// An accepted item leaves idle and its characters pass through a registered output stage, one
// character per cycle while out_stall_i is low; no new item is taken until its last character is
// pushed. Characters per item: 3 mid-line, 21 when it opens a line, 19 more when it fills one; an
// end command on n held bytes gives 3 * (16 - n) + n + 3, on an empty line none.
// Reset: sequencer idle, line empty, line address zero; the line buffer is not cleared.
module hex_dump_line_formatter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hdlf_pkg::AddrW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hdlf_pkg::CharW-1:0]   character_o,
  output logic                         run_last_o
);
  import hdlf_pkg::*;

  state_e              state_q, state_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [FillW-1:0]    idx_q, idx_d;
  logic [CountW-1:0]   n_q, n_d;
  logic                full_q, full_d;
  logic [7:0]          byte_q;
  logic [7:0]          rd_data_q;
  logic [7:0]          mem [BytesPerLine];

  logic   accept, slot_free, fire, ascii_last;
  beat_t  beat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign fire       = (state_q != S_IDLE) && slot_free;
  assign ascii_last = ({1'b0, idx_q} + CountW'(1)) == n_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CmdEnd) begin
            state_d = (fill_q != '0) ? S_PAD : S_IDLE;
          end else begin
            state_d = (fill_q == '0) ? S_ADDR : S_BYTE;
          end
        end
      end
      S_ADDR:  if (fire && cnt_q == 5'(NibbleCnt + 1)) state_d = S_BYTE;
      S_BYTE:  if (fire && cnt_q == 5'd2) state_d = full_q ? S_BAR : S_IDLE;
      S_PAD:   if (fire && cnt_q == 5'd2 && idx_q == FillW'(BytesPerLine - 1)) state_d = S_BAR;
      S_BAR:   if (fire) state_d = S_ASCII;
      S_ASCII: if (fire && ascii_last) state_d = S_CR;
      S_CR:    if (fire) state_d = S_LF;
      S_LF:    if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    beat.character = ChSpace;
    beat.run_last  = 1'b0;
    unique case (state_q)
      S_ADDR: begin
        if (cnt_q < 5'(NibbleCnt)) begin
          beat.character = hex_char(addr_q[{~cnt_q[3:0], 2'b00} +: 4]);
        end else if (cnt_q == 5'(NibbleCnt)) begin
          beat.character = ChColon;
        end
      end
      S_BYTE: begin
        if (cnt_q == 5'd0) begin
          beat.character = hex_char(byte_q[7:4]);
        end else if (cnt_q == 5'd1) begin
          beat.character = hex_char(byte_q[3:0]);
        end else begin
          beat.run_last = !full_q;
        end
      end
      S_PAD:   if (cnt_q != 5'd2) beat.character = ChZero;
      S_BAR:   beat.character = ChBar;
      S_ASCII: beat.character = shown_char(rd_data_q);
      S_CR:    beat.character = ChCr;
      S_LF: begin
        beat.character = ChLf;
        beat.run_last  = 1'b1;
      end
      S_IDLE:  beat.character = ChSpace;
      default: beat.character = ChSpace;
    endcase
  end

  // counters, fill and line address
  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    n_d    = n_q;
    full_d = full_q;
    fill_d = fill_q;
    addr_d = addr_q;
    if (accept) begin
      cnt_d = '0;
      if (command_i == CmdEnd) begin
        idx_d = fill_q;
        n_d   = {1'b0, fill_q};
        if (fill_q != '0) fill_d = '0;
      end else begin
        full_d = (fill_q == FillW'(BytesPerLine - 1));
        n_d    = CountW'(BytesPerLine);
        fill_d = fill_q + FillW'(1);
      end
    end else if (fire) begin
      case (state_q)
        S_ADDR:  cnt_d = (cnt_q == 5'(NibbleCnt + 1)) ? 5'd0 : cnt_q + 5'd1;
        S_BYTE:  cnt_d = (cnt_q == 5'd2) ? 5'd0 : cnt_q + 5'd1;
        S_PAD: begin
          if (cnt_q == 5'd2) begin
            cnt_d = '0;
            idx_d = idx_q + FillW'(1);
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
        S_BAR:   idx_d = '0;
        S_ASCII: if (!ascii_last) idx_d = idx_q + FillW'(1);
        S_LF:    addr_d = addr_q + AddrW'(BytesPerLine);
        default: cnt_d = cnt_q;
      endcase
    end
    if (cfg_we_i) begin
      addr_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      addr_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && command_i == CmdData) begin
      byte_q <= data_byte_i;
    end
  end

  // Line buffer: written on a data beat, read one entry ahead of the ASCII column.
  // Writes land many cycles before the close reads them, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CmdData) begin
      mem[fill_q] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[idx_d];
  end

  hdlf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .beat_i      (beat),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .run_last_o  (run_last_o)
  );

  a_fill_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(fill_q))
    else $error("fill count moved without an input beat");

  a_ascii_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCII) |-> ({1'b0, idx_q} < n_q))
    else $error("ASCII column index beyond held bytes");

  a_addr_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !(fire && state_q == S_LF)) |=> $stable(addr_q))
    else $error("line address changed outside a line close or write");

  a_lf_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q == S_LF) |=> (state_q == S_IDLE && fill_q == '0))
    else $error("line close did not return to idle with an empty line");

  a_close_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BAR) |-> (fill_q == '0))
    else $error("line closing while bytes still counted");

endmodule

// ===== rtl/core/hdlf_out_stage.sv =====
`timescale 1ns / 1ps

module hdlf_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  hdlf_pkg::beat_t              beat_i,
  output logic                         slot_free_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hdlf_pkg::CharW-1:0]   character_o,
  output logic                         run_last_o
);
  import hdlf_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign character_o = beat_q.character;
  assign run_last_o  = beat_q.run_last;

endmodule

// ===== verif/hex_dump_line_formatter_unit_chk.sv =====
`timescale 1ns / 1ps

module hex_dump_line_formatter_unit_chk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hdlf_pkg::AddrW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       command_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [hdlf_pkg::CharW-1:0] character_i,
  input  logic                       run_last_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  import hdlf_pkg::*;

  // predicted dump state
  logic [AddrW-1:0] line_addr = '0;
  logic [7:0]       line_buf [BytesPerLine];
  int               fill_cnt = 0;

  logic [CharW-1:0] item_text_q [$];  // characters of the item being predicted
  beat_t            dump_text_q [$];  // expected characters, oldest first
  int               err_cnt = 0;

  assign fail_count_o = err_cnt;
  assign pending_o    = dump_text_q.size();

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [CharW-1:0] hex_ascii(input logic [3:0] nib);
    string digits;
    byte   d;
    digits = "0123456789ABCDEF";
    d      = digits[nib];
    return d[CharW-1:0];
  endfunction

  function automatic void put_char(input logic [CharW-1:0] ch);
    item_text_q.push_back(ch);
  endfunction

  function automatic void close_line();
    for (int i = fill_cnt; i < BytesPerLine; i++) begin
      put_char(ChZero);
      put_char(ChZero);
      put_char(ChSpace);
    end
    put_char(ChBar);
    for (int i = 0; i < fill_cnt; i++) begin
      if (line_buf[i] >= {1'b0, ChSpace} && line_buf[i] <= {1'b0, ChTilde}) begin
        put_char(line_buf[i][CharW-1:0]);
      end else begin
        put_char(ChDot);
      end
    end
    put_char(ChCr);
    put_char(ChLf);
    line_addr = line_addr + AddrW'(BytesPerLine);
    fill_cnt  = 0;
  endfunction

  function automatic void predict_dump_text(input logic cmd, input logic [7:0] b);
    beat_t bt;
    item_text_q.delete();
    if (cmd == CmdEnd) begin
      if (fill_cnt != 0) close_line();
    end else begin
      if (fill_cnt == 0) begin
        for (int s = NibbleCnt - 1; s >= 0; s--) put_char(hex_ascii(line_addr[4*s +: 4]));
        put_char(ChColon);
        put_char(ChSpace);
      end
      put_char(hex_ascii(b[7:4]));
      put_char(hex_ascii(b[3:0]));
      put_char(ChSpace);
      line_buf[fill_cnt] = b;
      fill_cnt++;
      if (fill_cnt >= BytesPerLine) close_line();
    end
    foreach (item_text_q[i]) begin
      bt.character = item_text_q[i];
      bt.run_last  = (i == item_text_q.size() - 1);
      dump_text_q.push_back(bt);
    end
  endfunction

  // outputs are checked before inputs are predicted, so a beat never matches
  // an expectation pushed on the same edge
  always @(posedge clk_i) begin
    beat_t want;
    if (!rst_ni) begin
      line_addr = '0;
      fill_cnt  = 0;
      dump_text_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (dump_text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%02h last=%0b",
                                    character_i, run_last_i));
        end else begin
          want = dump_text_q.pop_front();
          if (character_i !== want.character)
            report_mismatch($sformatf("character got %02h want %02h",
                                      character_i, want.character));
          if (run_last_i !== want.run_last)
            report_mismatch($sformatf("run_last got %0b want %0b (char %02h)",
                                      run_last_i, want.run_last, want.character));
        end
      end
      if (cfg_we_i) line_addr = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_dump_text(command_i, data_byte_i);
    end
  end

endmodule

// ===== verif/hex_dump_line_formatter_unit_tb.sv =====
`timescale 1ns / 1ps

module hex_dump_line_formatter_unit_tb;

  import hdlf_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int          ItemsPerPhase = 150;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [AddrW-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             command = CmdData;
  logic [7:0]       data_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] character;
  logic             run_last;

  int          fail_count;
  int          pending;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int unsigned cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hex_dump_line_formatter_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .character_o (character),
    .run_last_o  (run_last)
  );

  hex_dump_line_formatter_unit_chk u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .character_i  (character),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL hex_dump_line_formatter_unit");
      $finish;
    end
  end

  // bytes around the printable range and the nibble extremes
  function automatic logic [7:0] boundary_byte(input int k);
    logic [7:0] b;
    case (k % 8)
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h1F;
      3:       b = 8'h20;
      4:       b = 8'h7E;
      5:       b = 8'h7F;
      6:       b = 8'h80;
      default: b = 8'h9A;
    endcase
    return b;
  endfunction

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [AddrW-1:0] base);
    wait_drained();
    // an end on an empty line gives no beat but may still be in flight
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [AddrW-1:0] base;
    logic [7:0]       b;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 38;
    stall_pct = 67;

    // reset address, end on empty line, one-byte line
    send_beat(CmdEnd, 8'hFF);
    send_beat(CmdData, 8'h00);
    send_beat(CmdEnd, 8'h00);

    // full line at the top of the address space, wraps to zero
    write_base(64'hFFFF_FFFF_FFFF_FFF0);
    for (int i = 0; i < BytesPerLine; i++) begin
      b = (i < 8) ? boundary_byte(i) : (8'h5A ^ 8'(i * 37));
      send_beat(CmdData, b);
    end

    // base reload in the middle of an open line
    send_beat(CmdData, 8'h7E);
    write_base(64'h0123_4567_89AB_CDEF);
    send_beat(CmdData, 8'h20);
    send_beat(CmdEnd, 8'h3C);
    send_beat(CmdEnd, 8'h00);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 38;
          stall_pct = 67;
          base      = '1;
        end
        1: begin
          gap_pct   = 67;
          stall_pct = 38;
          base      = '0;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
          base      = {$urandom, $urandom};
        end
      endcase
      write_base(base);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(24) == 0) begin
          send_beat(CmdEnd, 8'($urandom));
        end else if ($urandom_range(3) == 0) begin
          send_beat(CmdData, boundary_byte($urandom_range(7)));
        end else begin
          send_beat(CmdData, 8'($urandom));
        end
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS hex_dump_line_formatter_unit");
    end else begin
      $display("FAIL hex_dump_line_formatter_unit");
    end
    $finish;
  end

endmodule
